// ----- rtl/pvs_pkg.sv -----
`timescale 1ns / 1ps
package pvs_pkg;

  localparam int PARTICLE_COUNT = 1024;
  localparam int ADDR_W         = $clog2(PARTICLE_COUNT);
  localparam int IDX_W          = 10;
  localparam int IN_DATA_W      = 176;
  localparam int OUT_DATA_W     = 112;
  localparam int STAGES         = 10;

  localparam logic [IDX_W:0]  IDX_LIMIT = (IDX_W + 1)'(PARTICLE_COUNT);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PARTICLE_COUNT - 1);

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] prod_t;

  localparam q_t K_TENTH     = 32'sd6554;
  localparam q_t K_TWENTIETH = 32'sd3277;
  localparam q_t K_FIFTH     = 32'sd13107;
  localparam q_t K_HUNDREDTH = 32'sd655;
  localparam q_t K_HALF      = 32'sd32768;
  localparam q_t K_NINE10    = 32'sd58982;
  localparam q_t Q_MAX       = 32'sh7fff_ffff;
  localparam q_t Q_MIN       = 32'sh8000_0000;

  localparam prod_t Q_MAX64     = 64'sd2147483647;
  localparam prod_t Q_MIN64     = -64'sd2147483648;
  localparam prod_t ROUND_HALF  = 64'sd32768;
  localparam logic [63:0] CATCH_LIMIT = 64'h0000_0004_0000_0000;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // input word, last declared field (particle_index) in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    q_t               strength;
    q_t               vortex_z;
    q_t               vortex_x;
    q_t               load_z;
    q_t               load_x;
    logic [IDX_W-1:0] particle_index;
  } in_word_t;

  // one memory entry
  typedef struct packed {
    logic act;
    q_t   vz;
    q_t   vy;
    q_t   vx;
    q_t   z;
    q_t   y;
    q_t   x;
  } particle_t;

  // one result word
  typedef struct packed {
    logic             act;
    q_t               z;
    q_t               y;
    q_t               x;
    logic [IDX_W-1:0] idx;
  } res_t;

  // everything an item carries down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    logic             step;
    logic             caught;
    logic             act;
    logic             floor_hit;
    q_t               x;
    q_t               y;
    q_t               z;
    q_t               vx;
    q_t               vy;
    q_t               vz;
    q_t               cx;
    q_t               cz;
    q_t               s;
    q_t               lx;
    q_t               lz;
    q_t               dx;
    q_t               dz;
    q_t               ma;
    q_t               mb;
    q_t               mc;
    q_t               md;
    q_t               fs;
    q_t               tx;
    q_t               tz;
    q_t               ax;
    q_t               az;
    prod_t            p0;
    prod_t            p1;
    prod_t            p2;
    prod_t            p3;
    prod_t            p4;
    prod_t            p5;
    prod_t            p6;
  } pipe_t;

  function automatic q_t sat64(input prod_t v);
    q_t r;
    if (v > Q_MAX64) begin
      r = Q_MAX;
    end else if (v < Q_MIN64) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic prod_t sext(input q_t a);
    prod_t r;
    r = {{32{a[31]}}, a};
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    prod_t s;
    s = sext(a) + sext(b);
    return sat64(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    prod_t s;
    s = sext(a) - sext(b);
    return sat64(s);
  endfunction

  function automatic q_t qneg(input q_t a);
    prod_t s;
    s = 64'sd0 - sext(a);
    return sat64(s);
  endfunction

  function automatic prod_t qmul_raw(input q_t a, input q_t b);
    prod_t r;
    r = a * b;
    return r;
  endfunction

  // floor((p + 0.5 lsb) / 2^16), then saturate
  function automatic q_t qround(input prod_t p);
    prod_t q;
    prod_t r;
    q = p + ROUND_HALF;
    r = q >>> 16;
    return sat64(r);
  endfunction

endpackage

// ----- rtl/particle_vortex_step_unit.sv -----
`timescale 1ns / 1ps
// particle store with one load or vortex step per item
// in_* carries one word per item: in_tuser selects load or step, in_tdata holds the
// particle index, the load position and the vortex centre and strength. out_* returns
// one word per item with the particle index, position and active flag after the item.
// all values are signed Q16.16 with saturating arithmetic.
// path: an accepted word runs through stages 1 to 10 and the output buffer to out_*.
// throughput: one word per cycle while the output buffer has room and consecutive
// words name different particles; a word whose index is still in the 10-stage pipeline
// waits until that particle has been written back, so a particle takes a new word
// only once the last word on it has left the pipeline.
// reset: a clearing pass walks the particle memory, one entry per cycle, and clears
// every active flag; in_tready stays low until the pass has covered all 1024 entries.
// stall: results collect in a two-word output buffer; while it is full the pipeline
// holds and in_tready drops, nothing is lost or repeated.
module particle_vortex_step_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // particle_index, load_x, load_z, vortex_x, vortex_z, strength, zero pad
  input  logic [pvs_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_index, out_x, out_y, out_z, out_active, zero pad
  output logic [pvs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pvs_pkg::*;

  in_word_t         in_w;
  logic             in_hs;
  logic             hazard;
  logic             adv;

  logic             clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  particle_t        mem [PARTICLE_COUNT];
  particle_t        rd_r;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;
  particle_t        mem_wd;

  pipe_t            st_r   [1:STAGES];
  pipe_t            st_nxt [1:STAGES];
  logic [STAGES:1]  st_v_r;
  pipe_t            fin;
  particle_t        wb;
  res_t             res_in;

  res_t             ob0_r, ob1_r, ob0_nxt, ob1_nxt;
  logic [1:0]       ob_cnt_r, ob_cnt_nxt;
  logic             push, pop;

  assign in_w = in_tdata;

  // output buffer has room, so the pipeline may move
  assign adv       = (ob_cnt_r != 2'd2);
  assign in_tready = adv && !clr_busy_r && !hazard;
  assign in_hs     = in_tvalid && in_tready;

  // interlock on any item of the same particle not yet written back
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= STAGES; k++) begin
      if (st_v_r[k] && (st_r[k].idx == in_w.particle_index)) begin
        hazard = 1'b1;
      end
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == ADDR_LAST) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // particle memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_hs) begin
      rd_r <= mem[in_w.particle_index[ADDR_W-1:0]];
    end
  end

  // pipeline datapath
  always_comb begin
    logic [63:0] d2;
    q_t          ya;

    st_nxt[1]      = '0;
    st_nxt[1].idx  = in_w.particle_index;
    st_nxt[1].ok   = ({1'b0, in_w.particle_index} < IDX_LIMIT);
    st_nxt[1].step = (in_tuser == OP_STEP);
    st_nxt[1].cx   = in_w.vortex_x;
    st_nxt[1].cz   = in_w.vortex_z;
    st_nxt[1].s    = in_w.strength;
    st_nxt[1].lx   = in_w.load_x;
    st_nxt[1].lz   = in_w.load_z;

    // state from memory, or fresh values for a load
    st_nxt[2] = st_r[1];
    if (st_r[1].step) begin
      st_nxt[2].x   = rd_r.x;
      st_nxt[2].y   = rd_r.y;
      st_nxt[2].z   = rd_r.z;
      st_nxt[2].vx  = rd_r.vx;
      st_nxt[2].vy  = rd_r.vy;
      st_nxt[2].vz  = rd_r.vz;
      st_nxt[2].act = rd_r.act;
    end else begin
      st_nxt[2].x   = st_r[1].lx;
      st_nxt[2].y   = K_HALF;
      st_nxt[2].z   = st_r[1].lz;
      st_nxt[2].vx  = '0;
      st_nxt[2].vy  = '0;
      st_nxt[2].vz  = '0;
      st_nxt[2].act = 1'b0;
    end
    st_nxt[2].dx = qsub(st_nxt[2].x, st_r[1].cx);
    st_nxt[2].dz = qsub(st_nxt[2].z, st_r[1].cz);

    // squares for the radius test, constant products for the swirl and lift
    st_nxt[3]    = st_r[2];
    st_nxt[3].p0 = qmul_raw(st_r[2].dx, st_r[2].dx);
    st_nxt[3].p1 = qmul_raw(st_r[2].dz, st_r[2].dz);
    st_nxt[3].p2 = qmul_raw(st_r[2].dz, K_TENTH);
    st_nxt[3].p3 = qmul_raw(st_r[2].dx, K_TWENTIETH);
    st_nxt[3].p4 = qmul_raw(st_r[2].dx, K_TENTH);
    st_nxt[3].p5 = qmul_raw(st_r[2].dz, K_TWENTIETH);
    st_nxt[3].p6 = qmul_raw(st_r[2].s, K_FIFTH);

    st_nxt[4]        = st_r[3];
    d2               = st_r[3].p0 + st_r[3].p1;
    st_nxt[4].caught = st_r[3].step && st_r[3].ok && (d2 < CATCH_LIMIT);
    st_nxt[4].ma     = qround(st_r[3].p2);
    st_nxt[4].mb     = qround(st_r[3].p3);
    st_nxt[4].mc     = qround(st_r[3].p4);
    st_nxt[4].md     = qround(st_r[3].p5);
    st_nxt[4].fs     = qround(st_r[3].p6);

    st_nxt[5]    = st_r[4];
    st_nxt[5].tx = qsub(qneg(st_r[4].ma), st_r[4].mb);
    st_nxt[5].tz = qsub(st_r[4].mc, st_r[4].md);

    st_nxt[6]    = st_r[5];
    st_nxt[6].p0 = qmul_raw(st_r[5].tx, st_r[5].s);
    st_nxt[6].p1 = qmul_raw(st_r[5].tz, st_r[5].s);

    st_nxt[7]    = st_r[6];
    st_nxt[7].ax = qround(st_r[6].p0);
    st_nxt[7].az = qround(st_r[6].p1);

    // swirl and lift
    st_nxt[8] = st_r[7];
    if (st_r[7].caught) begin
      st_nxt[8].vx  = qadd(st_r[7].vx, st_r[7].ax);
      st_nxt[8].vz  = qadd(st_r[7].vz, st_r[7].az);
      st_nxt[8].vy  = qadd(st_r[7].vy, st_r[7].fs);
      st_nxt[8].act = 1'b1;
    end

    // gravity and horizontal integration
    st_nxt[9] = st_r[8];
    if (st_r[8].act) begin
      st_nxt[9].vy = qsub(st_r[8].vy, K_HUNDREDTH);
      st_nxt[9].x  = qadd(st_r[8].x, st_r[8].vx);
      st_nxt[9].z  = qadd(st_r[8].z, st_r[8].vz);
    end

    // height, floor test, friction products
    st_nxt[10] = st_r[9];
    ya         = qadd(st_r[9].y, st_r[9].vy);
    if (st_r[9].act) begin
      st_nxt[10].y = ya;
    end
    st_nxt[10].floor_hit = st_r[9].act && (ya < K_HALF);
    st_nxt[10].p0        = qmul_raw(st_r[9].vx, K_NINE10);
    st_nxt[10].p1        = qmul_raw(st_r[9].vz, K_NINE10);

    fin = st_r[10];
    if (st_r[10].floor_hit) begin
      fin.y  = K_HALF;
      fin.vy = '0;
      fin.vx = qround(st_r[10].p0);
      fin.vz = qround(st_r[10].p1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= '0;
    end else if (adv) begin
      st_v_r <= {st_v_r[STAGES-1:1], in_hs};
    end
  end

  // write back
  always_comb begin
    wb.act = fin.act;
    wb.x   = fin.x;
    wb.y   = fin.y;
    wb.z   = fin.z;
    wb.vx  = fin.vx;
    wb.vy  = fin.vy;
    wb.vz  = fin.vz;
  end

  assign mem_we = clr_busy_r || (st_v_r[STAGES] && adv && fin.ok);
  assign mem_wa = clr_busy_r ? clr_addr_r : fin.idx[ADDR_W-1:0];
  assign mem_wd = clr_busy_r ? particle_t'('0) : wb;

  // result, position and active flag zero for an index beyond the store
  always_comb begin
    res_in     = '0;
    res_in.idx = fin.idx;
    if (fin.ok) begin
      res_in.x   = fin.x;
      res_in.y   = fin.y;
      res_in.z   = fin.z;
      res_in.act = fin.act;
    end
  end

  // two-word output buffer
  assign push = st_v_r[STAGES] && adv;
  assign pop  = (ob_cnt_r != 2'd0) && out_tready;

  always_comb begin
    ob0_nxt    = ob0_r;
    ob1_nxt    = ob1_r;
    ob_cnt_nxt = ob_cnt_r;
    if (pop) begin
      ob0_nxt = ob1_r;
    end
    if (push) begin
      if ((ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && pop)) begin
        ob0_nxt = res_in;
      end else begin
        ob1_nxt = res_in;
      end
    end
    case ({push, pop})
      2'b10:   ob_cnt_nxt = ob_cnt_r + 2'd1;
      2'b01:   ob_cnt_nxt = ob_cnt_r - 2'd1;
      default: ob_cnt_nxt = ob_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ob0_r <= ob0_nxt;
    ob1_r <= ob1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= '0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  assign out_tvalid = (ob_cnt_r != 2'd0);
  assign out_tdata  = OUT_DATA_W'(ob0_r);

endmodule

// ----- rtl/pvs_check.sv -----
`timescale 1ns / 1ps
module pvs_check (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pvs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pvs_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped while stalled");

  // reset starts the clearing pass, no word is taken
  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  // reset empties the pipeline and output buffer
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word present right after reset");

endmodule

bind particle_vortex_step_unit pvs_check u_pvs_check (.*);
